>>> hdl/sult_pkg.sv
// ----------------------------------------------------------------------------
// sult_pkg
// types and codes shared by the sorted unique list table and its cells
// ----------------------------------------------------------------------------
package sult_pkg;

  localparam int unsigned DEPTH_DEF = 16;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_SEARCH = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_DONE     = 3'd0,
    ST_DUP      = 3'd1,
    ST_FULL     = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_EMPTY    = 3'd4
  } status_t;

  typedef struct packed {
    op_t                operation;
    logic signed [31:0] value;
  } in_t;

  typedef struct packed {
    status_t    status;
    logic [3:0] position;
    logic [4:0] count;
  } out_t;

  // what one cell hands to its right neighbor
  typedef struct packed {
    logic signed [31:0] entry;
    logic               gt;
    logic               used;
    logic               hit;
  } link_t;

  // commands broadcast to every cell
  typedef struct packed {
    logic ins_en;
    logic rem_en;
  } cmd_t;

endpackage

>>> hdl/sorted_unique_list_table.sv
// ----------------------------------------------------------------------------
// sorted_unique_list_table
// bounded ascending set of distinct signed 32-bit values in a row of cells
// ----------------------------------------------------------------------------
// Each input transaction carries an operation (insert, remove, search) and a
// value; each produces exactly one result transaction with a status, the
// position of the found or removed value and the entry count afterwards.
// Every cell compares its entry with the value in parallel; inserts shift
// the larger entries one cell right, removes pull the entries above the hit
// one cell left, all in the cycle of acceptance.
// The result is registered in the cycle after the input transaction is
// accepted. Throughput: one transaction per cycle while the receiver does
// not stall, set by the single compare-and-shift pass through the cell row.
// The input is stalled only while a result waits in the output register and
// the receiver stalls; the pending result then holds still.
// Reset empties the table (count zero) and drops any pending result; the
// cell contents are not cleared, since slots above the count are never read.
// ----------------------------------------------------------------------------
module sorted_unique_list_table
  import sult_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned PW = $clog2(DEPTH);

  logic [CW-1:0]      count_r;
  logic [CW-1:0]      count_nxt;
  logic               out_valid_r;
  logic               out_valid_nxt;
  out_t               out_data_r;
  out_t               out_data_nxt;

  logic               accept;
  logic               full;
  logic               empty;
  logic               found;
  logic [PW-1:0]      pos;
  cmd_t               cmd;
  link_t              links [DEPTH+1];
  logic               eqs   [DEPTH];
  logic               used  [DEPTH];

  assign accept = in_valid && !in_stall;
  assign in_stall = out_valid_r && out_stall;
  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);

  assign links[0].entry = '0;
  assign links[0].gt    = 1'b0;
  assign links[0].used  = 1'b1;
  assign links[0].hit   = 1'b0;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    assign used[g] = (CW'(g) < count_r);
    sult_cell u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .value       (in_data.value),
      .used        (used[g]),
      .left        (links[g]),
      .right_entry ((g + 1 < DEPTH) ? links[(g + 1 < DEPTH) ? g + 2 : g + 1].entry
                                    : links[g + 1].entry),
      .right       (links[g+1]),
      .eq          (eqs[g])
    );
  end

  always_comb begin
    pos = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (eqs[i]) begin
        pos = pos | PW'(i);
      end
    end
  end

  assign found = links[DEPTH].hit;

  always_comb begin
    cmd.ins_en   = 1'b0;
    cmd.rem_en   = 1'b0;
    count_nxt    = count_r;
    out_data_nxt = out_data_r;
    if (accept) begin
      out_data_nxt.status   = ST_DONE;
      out_data_nxt.position = '0;
      unique case (in_data.operation)
        OP_INSERT: begin
          if (full) begin
            out_data_nxt.status = ST_FULL;
          end else if (found) begin
            out_data_nxt.status = ST_DUP;
          end else begin
            cmd.ins_en = 1'b1;
            count_nxt  = count_r + 1'b1;
          end
        end
        OP_REMOVE, OP_SEARCH: begin
          if (empty) begin
            out_data_nxt.status = ST_EMPTY;
          end else if (!found) begin
            out_data_nxt.status = ST_NOTFOUND;
          end else begin
            out_data_nxt.position = 4'(pos);
            if (in_data.operation == OP_REMOVE) begin
              cmd.rem_en = 1'b1;
              count_nxt  = count_r - 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
      out_data_nxt.count = 5'(count_nxt);
    end
  end

  assign out_valid_nxt = accept || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count beyond table depth");

  a_result_follows : assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("accepted transaction produced no result");

  a_insert_grows : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins_en |=> count_r == $past(count_r) + 1'b1)
    else $error("insert did not grow the table");

  a_remove_pos : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rem_en |-> CW'(pos) < count_r)
    else $error("removed position outside the used entries");

endmodule

>>> hdl/sult_cell.sv
// ----------------------------------------------------------------------------
// sult_cell
// one table slot: holds an entry, compares it with the lookup value and
// takes its neighbor's entry, or the inserted value, when the table shifts
// ----------------------------------------------------------------------------
module sult_cell
  import sult_pkg::*;
(
  input  logic               clk,
  input  cmd_t               cmd,
  input  logic signed [31:0] value,
  input  logic               used,
  input  link_t              left,
  input  logic signed [31:0] right_entry,
  output link_t              right,
  output logic               eq
);

  logic signed [31:0] entry_r;
  logic signed [31:0] entry_nxt;
  logic               gt;
  logic               place;

  assign gt    = used && (entry_r > value);
  assign eq    = used && (entry_r == value);
  assign place = !left.gt && (gt || (!used && left.used));

  assign right.entry = entry_r;
  assign right.gt    = gt;
  assign right.used  = used;
  assign right.hit   = left.hit || eq;

  always_comb begin
    entry_nxt = entry_r;
    if (cmd.ins_en) begin
      if (left.gt) begin
        entry_nxt = left.entry;
      end else if (place) begin
        entry_nxt = value;
      end
    end else if (cmd.rem_en && right.hit) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

>>> test/list_table_checker.sv
// ----------------------------------------------------------------------------
// list_table_checker
// watches both channels of the sorted unique list table and checks results
// ----------------------------------------------------------------------------
// Keeps its own ascending table and count. Every accepted input transaction
// is applied to that table and the result it should produce is queued; every
// accepted result transaction is compared field by field with the oldest
// queued result. Mismatches and results with nothing queued are counted.
// ----------------------------------------------------------------------------
module list_table_checker
  import sult_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_stall,
  input  in_t  in_data,
  input  logic out_valid,
  input  logic out_stall,
  input  out_t out_data,
  output int   errors,
  output int   pending
);

  logic signed [31:0] slots [DEPTH];
  int                 fill;
  out_t               result_q [$];
  out_t               want;

  task automatic report_mismatch(string what, int got, int exp_val);
    $display("list_table_checker: %s: got %0d, expected %0d at %0t", what, got, exp_val,
             $realtime);
    errors++;
  endtask

  // applies one transaction to the table and returns its result
  function automatic out_t apply_op(in_t t);
    out_t               r;
    int                 hit;
    int                 i;
    logic signed [31:0] v;
    v          = t.value;
    r.status   = ST_DONE;
    r.position = '0;
    hit        = -1;
    for (i = 0; i < fill; i++) begin
      if (slots[i] == v) begin
        hit = i;
        break;
      end
      if (slots[i] > v) break;
    end
    case (t.operation)
      OP_INSERT: begin
        if (fill >= DEPTH) begin
          r.status = ST_FULL;
        end else if (hit >= 0) begin
          r.status = ST_DUP;
        end else begin
          i = fill;
          while (i > 0 && slots[i-1] > v) begin
            slots[i] = slots[i-1];
            i--;
          end
          slots[i] = v;
          fill++;
        end
      end
      OP_REMOVE, OP_SEARCH: begin
        if (fill == 0) begin
          r.status = ST_EMPTY;
        end else if (hit < 0) begin
          r.status = ST_NOTFOUND;
        end else begin
          r.position = 4'(hit);
          if (t.operation == OP_REMOVE) begin
            for (i = hit; i + 1 < fill; i++) slots[i] = slots[i+1];
            fill--;
          end
        end
      end
      default: ;
    endcase
    r.count = 5'(fill);
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      fill = 0;
      result_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (result_q.size() == 0) begin
          report_mismatch("result with nothing outstanding", int'(out_data.count), -1);
        end else begin
          want = result_q.pop_front();
          if (out_data.status !== want.status)
            report_mismatch("status", int'(out_data.status), int'(want.status));
          if (out_data.position !== want.position)
            report_mismatch("position", int'(out_data.position), int'(want.position));
          if (out_data.count !== want.count)
            report_mismatch("count", int'(out_data.count), int'(want.count));
        end
      end
      if (in_valid && !in_stall) result_q.push_back(apply_op(in_data));
    end
    pending = result_q.size();
  end

endmodule

>>> test/tb_sorted_unique_list_table.sv
// ----------------------------------------------------------------------------
// tb_sorted_unique_list_table
// stimulus and verdict for the sorted unique list table
// ----------------------------------------------------------------------------
// Drives a directed sequence (empty, duplicate, full, extremes, removal at
// full count, the unused operation code), then phases of random transactions
// that swing between insert-heavy and remove-heavy mixes over a small value
// pool, so the table fills and drains repeatedly. Both sides idle at random,
// and twice the receiver holds off long enough to back the block up. The
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_sorted_unique_list_table;
  import sult_pkg::*;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;
  int   errors;
  int   pending;
  int   idle_pct;
  int   stall_pct;
  bit   hold_req;

  sorted_unique_list_table uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  list_table_checker chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .errors    (errors),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #30000000;
    $display("tb_sorted_unique_list_table: done, errors");
    $finish;
  end

  // mostly short, a few long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic in_t mk_item(op_t op, logic signed [31:0] v);
    in_t t;
    t.operation = op;
    t.value     = v;
    return t;
  endfunction

  // small pool so hits and duplicates are common, plus extremes and full range
  function automatic logic signed [31:0] pick_value();
    int r;
    int k;
    r = $urandom_range(0, 19);
    if (r == 0) begin
      case ($urandom_range(0, 3))
        0: return 32'sh8000_0000;
        1: return 32'sh7fff_ffff;
        2: return 32'sd0;
        default: return -32'sd1;
      endcase
    end
    if (r <= 2) return $urandom;
    k = $urandom_range(0, 23);
    return k - 12;
  endfunction

  function automatic op_t pick_operation(int ins_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < 2) return OP_NONE;
    if (r < ins_pct) return OP_INSERT;
    return $urandom_range(0, 1) ? OP_REMOVE : OP_SEARCH;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_item(in_t t);
    int gap;
    gap = ($urandom_range(0, 99) < idle_pct) ? gap_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // receiver stalls, with a long hold-off on request
  initial begin
    int left;
    bit stall_now;
    out_stall = 1'b0;
    left      = 0;
    stall_now = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (64) @(negedge clk);
        out_stall <= 1'b0;
        left      = 0;
        stall_now = 1'b0;
      end else begin
        if (left == 0) begin
          stall_now = ($urandom_range(0, 99) < stall_pct);
          left      = stall_now ? gap_len() : $urandom_range(1, 24);
        end
        out_stall <= stall_now;
        left--;
      end
    end
  end

  initial begin
    int p;
    int i;
    int ins_pct;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    idle_pct  = 0;
    stall_pct = 0;
    hold_req  = 1'b0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part
    send_item(mk_item(OP_SEARCH, 32'sd5));
    send_item(mk_item(OP_REMOVE, 32'sd5));
    send_item(mk_item(OP_NONE, 32'sd0));
    send_item(mk_item(OP_INSERT, 32'sd0));
    send_item(mk_item(OP_INSERT, 32'sd0));
    send_item(mk_item(OP_INSERT, 32'sh8000_0000));
    send_item(mk_item(OP_INSERT, 32'sh7fff_ffff));
    send_item(mk_item(OP_INSERT, -32'sd1));
    send_item(mk_item(OP_SEARCH, -32'sd1));
    send_item(mk_item(OP_SEARCH, 32'sd1));
    send_item(mk_item(OP_SEARCH, 32'sh8000_0000));
    send_item(mk_item(OP_REMOVE, 32'sh7fff_ffff));
    send_item(mk_item(OP_REMOVE, 32'sd7));
    for (i = 1; i <= 13; i++) send_item(mk_item(OP_INSERT, i));
    send_item(mk_item(OP_INSERT, 32'sd50));
    send_item(mk_item(OP_INSERT, 32'sd0));
    send_item(mk_item(OP_SEARCH, 32'sd13));
    send_item(mk_item(OP_REMOVE, 32'sd13));
    send_item(mk_item(OP_INSERT, 32'sd13));
    send_item(mk_item(OP_REMOVE, 32'sh8000_0000));
    send_item(mk_item(OP_NONE, 32'sh7fff_ffff));

    // random phases swinging the table between full and empty
    for (p = 0; p < 35; p++) begin
      case (p % 3)
        0: ins_pct = 80;
        1: ins_pct = 50;
        default: ins_pct = 25;
      endcase
      case ($urandom_range(0, 2))
        0: idle_pct = 0;
        1: idle_pct = 20;
        default: idle_pct = 50;
      endcase
      case ($urandom_range(0, 2))
        0: stall_pct = 0;
        1: stall_pct = 30;
        default: stall_pct = 60;
      endcase
      if (p == 3 || p == 20) begin
        hold_req = 1'b1;
        idle_pct = 0;
      end
      repeat (50) send_item(mk_item(pick_operation(ins_pct), pick_value()));
    end
    in_valid <= 1'b0;

    wait (pending == 0);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("tb_sorted_unique_list_table: done, clean");
    end else begin
      $display("tb_sorted_unique_list_table: done, errors");
    end
    $finish;
  end

endmodule
